[rtl/core/tsb_pkg.sv]
// Shared types, constants and helpers for the two-stack text buffer.
`timescale 1ns / 1ps

package tsb_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int MODE_W           = 3;
  localparam int CHAR_W           = 8;
  localparam int POS_W            = 9;
  localparam int IN_DATA_W        = 8;
  localparam int OUT_DATA_W       = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_FORWARD = 3'd0,
    MODE_BACK    = 3'd1,
    MODE_START   = 3'd2,
    MODE_END     = 3'd3,
    MODE_WORD    = 3'd4,
    MODE_INSERT  = 3'd5,
    MODE_DELETE  = 3'd6
  } mode_t;

  typedef struct packed {
    logic              insert_dropped;
    logic              has_char_at_cursor;
    logic [CHAR_W-1:0] char_at_cursor;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor_pos;
  } result_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

[rtl/core/two_stack_text_buffer_top.sv]
// Top level of the two-stack text buffer: input handshake and output register.
//
//   channel | dir | fields (low bit first)
//   s_*     | in  | tuser: mode[2:0]; tdata: char_in[7:0]
//   m_*     | out | tdata: cursor_pos[8:0], text_length[17:9], char_at_cursor[25:18],
//           |     |        has_char_at_cursor[26], insert_dropped[27], zero[31:28]
//
// Insert, delete, forward, back and the unused mode take a single step; delete, forward
// and back then reload a stack top from its store. Start, end and word begin step one
// character at a time, and word begin spends a step of its own leaving blanks for a word.
// One item is in work at a time; the next is taken while a result waits in m_tdata.
// rst empties the buffer; the byte stores need no clearing.
`timescale 1ns / 1ps

module two_stack_text_buffer_top #(
  parameter int CAPACITY = tsb_pkg::DEFAULT_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tsb_pkg::IN_DATA_W-1:0]   s_tdata,   // char_in[7:0]
  input  logic [tsb_pkg::MODE_W-1:0]      s_tuser,   // mode[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tsb_pkg::OUT_DATA_W-1:0]  m_tdata    // cursor_pos, text_length, char, has, dropped
);

  logic             idle, done, out_free;
  tsb_pkg::result_t result;

  assign s_tready = idle;
  assign out_free = !m_tvalid || m_tready;

  tsb_core #(.CAPACITY(CAPACITY)) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid),
    .mode     (tsb_pkg::mode_t'(s_tuser)),
    .char_in  (s_tdata),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= tsb_pkg::OUT_DATA_W'(result);
    end
  end

endmodule

[rtl/core/tsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tsb_core.sv]
// Command engine: stack counts, cached stack tops and the two byte stores.
`timescale 1ns / 1ps

module tsb_core #(
  parameter int CAPACITY = tsb_pkg::DEFAULT_CAPACITY,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  tsb_pkg::mode_t              mode,
  input  logic [tsb_pkg::CHAR_W-1:0]  char_in,
  input  logic                        out_free,
  output logic                        idle,
  output logic                        done,
  output tsb_pkg::result_t            result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [CW:0] CAP_SUM = (CW + 1)'(CAPACITY);

  state_t                      state, state_next;
  logic [CW-1:0]               fc, fc_next, bc, bc_next;
  logic [tsb_pkg::CHAR_W-1:0]  front_top, front_top_next, back_top, back_top_next;
  tsb_pkg::mode_t              mode_r;
  logic [tsb_pkg::CHAR_W-1:0]  char_r;
  logic                        phase, phase_next;
  logic                        last, last_next;
  logic                        load_front, load_front_next;
  logic                        dropped, dropped_next;

  logic                        f_we, f_re, b_we, b_re;
  logic [AW-1:0]               f_waddr, f_raddr, b_waddr, b_raddr;
  logic [tsb_pkg::CHAR_W-1:0]  f_wdata, b_wdata, f_rdata, b_rdata;

  logic [CW-1:0]               fc_m2, bc_m2;
  logic [CW:0]                 total;
  logic [CW+tsb_pkg::POS_W-1:0] fc_ext, len_ext;
  logic                        do_back, do_fwd;

  assign fc_m2   = fc - CW'(2);
  assign bc_m2   = bc - CW'(2);
  assign total   = (CW + 1)'(fc) + (CW + 1)'(bc);
  assign fc_ext  = (CW + tsb_pkg::POS_W)'(fc);
  assign len_ext = (CW + tsb_pkg::POS_W)'(total);

  always_comb begin
    state_next      = state;
    fc_next         = fc;
    bc_next         = bc;
    front_top_next  = front_top;
    back_top_next   = back_top;
    phase_next      = phase;
    last_next       = last;
    load_front_next = load_front;
    dropped_next    = dropped;
    f_we = 1'b0; f_waddr = '0; f_wdata = back_top;
    b_we = 1'b0; b_waddr = '0; b_wdata = front_top;
    f_re = 1'b0; f_raddr = '0;
    b_re = 1'b0; b_raddr = '0;
    do_back = 1'b0;
    do_fwd  = 1'b0;
    done    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          phase_next   = 1'b0;
          dropped_next = 1'b0;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_OUT;
        unique case (mode_r)
          tsb_pkg::MODE_FORWARD: begin
            do_fwd    = (bc != '0);
            last_next = 1'b1;
          end
          tsb_pkg::MODE_BACK: begin
            do_back   = (fc != '0);
            last_next = 1'b1;
          end
          tsb_pkg::MODE_START: begin
            do_back   = (fc != '0);
            last_next = 1'b0;
          end
          tsb_pkg::MODE_END: begin
            do_fwd    = (bc != '0);
            last_next = 1'b0;
          end
          tsb_pkg::MODE_WORD: begin
            last_next = 1'b0;
            if (fc != '0) begin
              if (!phase) begin
                if (tsb_pkg::is_blank(front_top)) begin
                  do_back = 1'b1;
                end else begin
                  phase_next = 1'b1;
                  state_next = ST_EXEC;
                end
              end else begin
                do_back = !tsb_pkg::is_blank(front_top);
              end
            end
          end
          tsb_pkg::MODE_INSERT: begin
            if (total >= CAP_SUM) begin
              dropped_next = 1'b1;
            end else begin
              f_we           = 1'b1;
              f_waddr        = fc[AW-1:0];
              f_wdata        = char_r;
              fc_next        = fc + CW'(1);
              front_top_next = char_r;
            end
          end
          tsb_pkg::MODE_DELETE: begin
            if (bc != '0) begin
              bc_next         = bc - CW'(1);
              b_re            = (bc > CW'(1));
              b_raddr         = bc_m2[AW-1:0];
              load_front_next = 1'b0;
              last_next       = 1'b1;
              state_next      = ST_LOAD;
            end
          end
          default: begin
          end
        endcase
        if (do_back) begin
          b_we            = 1'b1;
          b_waddr         = bc[AW-1:0];
          b_wdata         = front_top;
          bc_next         = bc + CW'(1);
          fc_next         = fc - CW'(1);
          back_top_next   = front_top;
          f_re            = (fc > CW'(1));
          f_raddr         = fc_m2[AW-1:0];
          load_front_next = 1'b1;
          state_next      = ST_LOAD;
        end
        if (do_fwd) begin
          f_we            = 1'b1;
          f_waddr         = fc[AW-1:0];
          f_wdata         = back_top;
          fc_next         = fc + CW'(1);
          bc_next         = bc - CW'(1);
          front_top_next  = back_top;
          b_re            = (bc > CW'(1));
          b_raddr         = bc_m2[AW-1:0];
          load_front_next = 1'b0;
          state_next      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_front) begin
          front_top_next = f_rdata;
        end else begin
          back_top_next = b_rdata;
        end
        state_next = last ? ST_OUT : ST_EXEC;
      end
      ST_OUT: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fc      <= '0;
      bc      <= '0;
      phase   <= 1'b0;
      last    <= 1'b0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fc      <= fc_next;
      bc      <= bc_next;
      phase   <= phase_next;
      last    <= last_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    front_top  <= front_top_next;
    back_top   <= back_top_next;
    load_front <= load_front_next;
    if (state == ST_IDLE && start) begin
      mode_r <= mode;
      char_r <= char_in;
    end
  end

  assign idle = (state == ST_IDLE);

  always_comb begin
    result.cursor_pos         = fc_ext[tsb_pkg::POS_W-1:0];
    result.text_length        = len_ext[tsb_pkg::POS_W-1:0];
    result.has_char_at_cursor = (bc != '0);
    result.char_at_cursor     = (bc != '0) ? back_top : '0;
    result.insert_dropped     = dropped;
  end

  tsb_ram #(.WIDTH(tsb_pkg::CHAR_W), .DEPTH(CAPACITY)) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  tsb_ram #(.WIDTH(tsb_pkg::CHAR_W), .DEPTH(CAPACITY)) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

endmodule

[bench/tb_two_stack_text_buffer_top.sv]
// Testbench for the two-stack text buffer: a directed edit script, then random text sessions.
`timescale 1ns / 1ps

module tb_two_stack_text_buffer_top;
  import tsb_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int IDX_W = $clog2(CAP);
  localparam int SCRIPT_LEN = 25;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  localparam int unsigned SEND_IDLE [4] = '{0, 48, 0, 17};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 48, 17};
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned FULL_ITEMS_BEFORE_DRAIN = 8;

  localparam logic [MODE_W-1:0] MIX_OPS [7] = '{MODE_INSERT, MODE_DELETE, MODE_BACK,
    MODE_FORWARD, MODE_START, MODE_END, MODE_WORD};
  localparam int unsigned FILL_MIX [7] = '{78, 81, 86, 90, 92, 94, 97};
  localparam int unsigned DRAIN_MIX [7] = '{8, 55, 67, 72, 80, 84, 96};
  localparam logic [CHAR_W-1:0] NEAR_SPACE [4] = '{8'h08, 8'h0E, 8'h1F, 8'h21};

  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic [CHAR_W-1:0] ch;
    logic              fixed;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic [CHAR_W-1:0] at;
    logic              has;
    logic              drop;
  } script_row_t;

  // op, char, fixed, cursor, length, char after cursor, has char, dropped
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{MODE_FORWARD, 8'hFF, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_BACK,    8'h00, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_DELETE,  8'hA5, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_WORD,    8'h5A, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_START,   8'hFF, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_END,     8'h00, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_UNUSED,  8'hFF, 1'b1, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h61, 1'b1, 9'd1, 9'd1, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h20, 1'b1, 9'd2, 9'd2, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'hFF, 1'b1, 9'd3, 9'd3, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h09, 1'b1, 9'd4, 9'd4, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h0D, 1'b1, 9'd5, 9'd5, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h00, 1'b1, 9'd6, 9'd6, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h80, 1'b1, 9'd7, 9'd7, 8'h00, 1'b0, 1'b0},
    '{MODE_WORD,    8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_WORD,    8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_WORD,    8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_BACK,    8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_FORWARD, 8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_INSERT,  8'h08, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_DELETE,  8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_END,     8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_DELETE,  8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_START,   8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0},
    '{MODE_UNUSED,  8'h00, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 1'b0}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;

  logic [CHAR_W-1:0] left_bytes [CAP];
  logic [CHAR_W-1:0] right_bytes [CAP];
  int unsigned left_count = 0;
  int unsigned right_count = 0;
  result_t expected_status [$];
  result_t seen;
  result_t want;

  two_stack_text_buffer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit is_space(input logic [CHAR_W-1:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic void move_left();
    if (left_count > 0) begin
      left_count = left_count - 1;
      right_bytes[IDX_W'(right_count)] = left_bytes[IDX_W'(left_count)];
      right_count = right_count + 1;
    end
  endfunction

  function automatic void move_right();
    if (right_count > 0) begin
      right_count = right_count - 1;
      left_bytes[IDX_W'(left_count)] = right_bytes[IDX_W'(right_count)];
      left_count = left_count + 1;
    end
  endfunction

  function automatic result_t apply_edit(input logic [MODE_W-1:0] op,
                                         input logic [CHAR_W-1:0] ch);
    result_t r;
    logic dropped;
    dropped = 1'b0;
    case (op)
      MODE_FORWARD: move_right();
      MODE_BACK:    move_left();
      MODE_START:   while (left_count > 0) move_left();
      MODE_END:     while (right_count > 0) move_right();
      MODE_WORD: begin
        while (left_count > 0 && is_space(left_bytes[IDX_W'(left_count-1)])) move_left();
        while (left_count > 0 && !is_space(left_bytes[IDX_W'(left_count-1)])) move_left();
      end
      MODE_INSERT: begin
        if (left_count + right_count >= CAP) begin
          dropped = 1'b1;
        end else begin
          left_bytes[IDX_W'(left_count)] = ch;
          left_count = left_count + 1;
        end
      end
      MODE_DELETE: begin
        if (right_count > 0) right_count = right_count - 1;
      end
      default: ;
    endcase
    r.cursor_pos         = POS_W'(left_count);
    r.text_length        = POS_W'(left_count + right_count);
    r.has_char_at_cursor = (right_count > 0);
    r.char_at_cursor     = (right_count > 0) ? right_bytes[IDX_W'(right_count-1)] : 8'h00;
    r.insert_dropped     = dropped;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return CHAR_W'(8'h61 + $urandom_range(25));
    if (roll < 60) return 8'h20;
    if (roll < 70) return CHAR_W'(8'h09 + $urandom_range(4));
    if (roll < 80) return NEAR_SPACE[2'($urandom_range(3))];
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input bit use_fixed, input result_t fixed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    predicted = apply_edit(op, ch);
    expected_status.push_back(use_fixed ? fixed_res : predicted);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (expected_status.size() == 0) begin
        $error("unexpected result item: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        if (seen.cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, seen.cursor_pos);
          fail_count++;
        end
        if (seen.text_length !== want.text_length) begin
          $error("text_length: expected %0d, got %0d", want.text_length, seen.text_length);
          fail_count++;
        end
        if (seen.char_at_cursor !== want.char_at_cursor) begin
          $error("char_at_cursor: expected %h, got %h",
                 want.char_at_cursor, seen.char_at_cursor);
          fail_count++;
        end
        if (seen.has_char_at_cursor !== want.has_char_at_cursor) begin
          $error("has_char_at_cursor: expected %b, got %b",
                 want.has_char_at_cursor, seen.has_char_at_cursor);
          fail_count++;
        end
        if (seen.insert_dropped !== want.insert_dropped) begin
          $error("insert_dropped: expected %b, got %b",
                 want.insert_dropped, seen.insert_dropped);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    script_row_t row;
    result_t fixed_res;
    logic [MODE_W-1:0] op;
    logic [CHAR_W-1:0] ch;
    int unsigned roll;
    int unsigned full_items;
    bit filling;
    filling = 1'b1;
    full_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      fixed_res.cursor_pos         = row.pos;
      fixed_res.text_length        = row.len;
      fixed_res.char_at_cursor     = row.at;
      fixed_res.has_char_at_cursor = row.has;
      fixed_res.insert_dropped     = row.drop;
      send_item(row.op, row.ch, row.fixed, fixed_res);
    end

    // fill toward a full buffer, dwell there, then drain toward empty
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[2'(ph)];
      recv_stall_pct = RECV_STALL[2'(ph)];
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        ch = pick_byte();
        op = MODE_UNUSED;
        for (int k = 6; k >= 0; k--) begin
          if (roll < (filling ? FILL_MIX[3'(k)] : DRAIN_MIX[3'(k)])) op = MIX_OPS[3'(k)];
        end
        send_item(op, ch, 1'b0, '0);
        if (filling && left_count + right_count == CAP) begin
          full_items++;
          if (full_items >= FULL_ITEMS_BEFORE_DRAIN) begin
            filling = 1'b0;
            full_items = 0;
          end
        end else if (!filling && left_count + right_count == 0) begin
          filling = 1'b1;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tsb_pkg.sv
rtl/core/tsb_ram.sv
rtl/core/tsb_core.sv
rtl/core/two_stack_text_buffer_top.sv
bench/tb_two_stack_text_buffer_top.sv
